>>> src/lfhs_pkg.sv
// ----------------------------------------------------------------------------
// lfhs_pkg
// shared types, register indexes and helpers of the fire heat simulator
// ----------------------------------------------------------------------------
package lfhs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 3'd4;

    localparam int DIV_AW = 32;
    localparam int DIV_BW = 12;

    typedef struct packed {
        logic [6:0] speed;
        logic [6:0] intensity;
        logic [6:0] brightness;
        logic [6:0] pixel_count;
    } t_cfg;

    typedef struct packed {
        logic        seed_we;
        logic [31:0] seed;
    } t_seed;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

>>> src/lfhs_div.sv
// ----------------------------------------------------------------------------
// lfhs_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module lfhs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lfhs_pkg::DIV_AW-1:0]  i_num,
    input  logic [lfhs_pkg::DIV_BW-1:0]  i_den,
    output logic                         o_done,
    output logic [lfhs_pkg::DIV_AW-1:0]  o_quo,
    output logic [lfhs_pkg::DIV_BW-1:0]  o_rem
);
    localparam int CW = $clog2(lfhs_pkg::DIV_AW);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [lfhs_pkg::DIV_AW-1:0] r_quo;
    logic [lfhs_pkg::DIV_BW-1:0] r_rem;
    logic [lfhs_pkg::DIV_BW-1:0] r_den;
    logic [lfhs_pkg::DIV_BW:0]   trial;
    logic                        ge;
    logic [lfhs_pkg::DIV_BW:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[lfhs_pkg::DIV_AW-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(lfhs_pkg::DIV_AW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[lfhs_pkg::DIV_AW-2:0], ge};
            r_rem <= ge ? diff[lfhs_pkg::DIV_BW-1:0] : trial[lfhs_pkg::DIV_BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> src/lfhs_front.sv
// ----------------------------------------------------------------------------
// lfhs_front
// accepts frame ticks and marks those that start a new simulation step
// ----------------------------------------------------------------------------
module lfhs_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_time_ms,
    input  logic        i_full,
    output logic        o_stall,
    output logic        o_push,
    output logic        o_sim
);
    logic [26:0] r_last_it;
    logic [26:0] it;

    assign it      = i_time_ms[31:5];
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign o_sim   = it != r_last_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_it <= '0;
        end else if (o_push) begin
            r_last_it <= it;
        end
    end
endmodule

>>> src/lfhs_queue.sv
// ----------------------------------------------------------------------------
// lfhs_queue
// two entry queue of classified frame ticks
// ----------------------------------------------------------------------------
module lfhs_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_sim,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output logic o_sim
);
    logic [1:0] r_q;
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_sim   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_sim;
        end
    end
endmodule

>>> src/lfhs_back.sv
// ----------------------------------------------------------------------------
// lfhs_back
// heat store, simulation sequencer and pixel colour output
// ----------------------------------------------------------------------------
module lfhs_back #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lfhs_pkg::t_cfg       i_cfg,
    input  lfhs_pkg::t_seed      i_seed,
    input  logic [6:0]           i_n,
    input  logic                 i_q_valid,
    input  logic                 i_q_sim,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [5:0]           o_pixel_index,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic                 o_last_pixel
);
    localparam int AW = $clog2(MAX_PIXELS);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_PRE  = 5'd1;
    localparam logic [4:0] ST_LIM  = 5'd2;
    localparam logic [4:0] ST_CRD  = 5'd3;
    localparam logic [4:0] ST_CDV  = 5'd4;
    localparam logic [4:0] ST_DRD1 = 5'd5;
    localparam logic [4:0] ST_DRD2 = 5'd6;
    localparam logic [4:0] ST_DWR  = 5'd7;
    localparam logic [4:0] ST_SP1  = 5'd8;
    localparam logic [4:0] ST_SP2  = 5'd9;
    localparam logic [4:0] ST_SP3  = 5'd10;
    localparam logic [4:0] ST_SP4  = 5'd11;
    localparam logic [4:0] ST_SP5  = 5'd12;
    localparam logic [4:0] ST_SP6  = 5'd13;
    localparam logic [4:0] ST_ERD  = 5'd14;
    localparam logic [4:0] ST_E1   = 5'd15;
    localparam logic [4:0] ST_E2   = 5'd16;
    localparam logic [4:0] ST_E3   = 5'd17;
    localparam logic [4:0] ST_E4   = 5'd18;
    localparam logic [4:0] ST_EOUT = 5'd19;

    logic [4:0]  r_state;
    logic        r_sim;
    logic [6:0]  r_n;
    logic [6:0]  r_i;
    logic [6:0]  r_k;
    logic [31:0] r_rng;
    logic [10:0] r_limit;
    logic [2:0]  r_y;
    logic [8:0]  r_lo;
    logic [6:0]  r_rng_span;
    logic [7:0]  r_a;
    logic [15:0] r_t191;
    logic [7:0]  r_c [3];
    logic [14:0] r_p [3];
    logic        r_ovalid;
    logic [7:0]  r_ored;
    logic [7:0]  r_ogreen;
    logic [7:0]  r_oblue;

    // derived settings, registered
    logic [8:0]  r_sp;
    logic [8:0]  r_si;
    logic [11:0] r_x;
    logic [2:0]  r_ign;

    // heat store
    logic [7:0]            r_mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_hv;
    logic [7:0]            r_rdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_ra;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [7:0]            mem_wd;

    // divider
    logic                        r_div_start;
    logic [lfhs_pkg::DIV_AW-1:0] r_div_num;
    logic [lfhs_pkg::DIV_BW-1:0] r_div_den;
    logic                        div_done;
    logic [lfhs_pkg::DIV_AW-1:0] div_quo;
    logic [lfhs_pkg::DIV_BW-1:0] div_rem;

    logic [31:0] rng_next;
    logic [14:0] sp255;
    logic [27:0] sp_prod;
    logic [14:0] si255;
    logic [27:0] si_prod;
    logic [18:0] x_prod;
    logic [14:0] ign_prod;
    logic [2:0]  ign_q;
    logic [7:0]  cool;
    logic [7:0]  h_sub;
    logic [7:0]  flr;
    logic [9:0]  dsum;
    logic [20:0] dprod;
    logic [8:0]  boost_num;
    logic [7:0]  boost;
    logic [7:0]  spark;
    logic [8:0]  ssum;
    logic [7:0]  tcl;
    logic [16:0] tx;
    logic [16:0] t192w;
    logic [7:0]  t192;
    logic [7:0]  up;
    logic [27:0] sc [3];
    logic [8:0]  scq [3];
    logic [7:0]  scs [3];

    lfhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign rng_next = lfhs_pkg::xorshift(r_rng);

    always_comb begin
        sp255    = {1'b0, i_cfg.speed, 7'd0} + {1'b0, i_cfg.speed, 7'd0}
                   - {8'd0, i_cfg.speed};
        sp_prod  = 28'(sp255) * 28'd5243;
        si255    = {1'b0, i_cfg.intensity, 7'd0} + {1'b0, i_cfg.intensity, 7'd0}
                   - {8'd0, i_cfg.intensity};
        si_prod  = 28'(si255) * 28'd5243;
        x_prod   = 19'(r_sp) * 19'd683;
        ign_prod = 15'(r_n) * 15'd205;
        ign_q    = ign_prod[13:11];
    end

    always_ff @(posedge i_clk) begin
        r_sp  <= sp_prod[27:19];
        r_si  <= si_prod[27:19];
        r_x   <= 12'({4'd0, x_prod[18:11]} + 12'd20) << 4;
        r_ign <= (ign_q > 3'd3) ? ign_q : 3'd3;
    end

    // per-state datapath values
    always_comb begin
        cool      = div_rem[7:0];
        h_sub     = (r_rdata > cool) ? (r_rdata - cool) : 8'd0;
        flr       = (r_i < 7'(r_ign)) ? (8'(3'(r_ign - r_i[2:0]) >> 2) + 8'd16) : 8'd0;
        dsum      = {2'd0, r_a} + {1'b0, r_rdata, 1'b0};
        dprod     = 21'(dsum) * 21'd683;
        boost_num = 9'(3'(r_ign - (div_rem[2:0] >> 1))) * 9'd33;
        boost     = div_quo[7:0];
        spark     = 8'(r_lo + 9'(div_rem[6:0]));
        ssum      = {1'b0, r_rdata} + {1'b0, spark};
        tcl       = (r_rdata > 8'd240) ? 8'd240 : r_rdata;
        tx        = {1'b0, r_t191};
        t192w     = (tx + (tx >> 8) + 17'd1) >> 8;
        t192      = t192w[7:0];
        up        = {t192[5:0], 2'b00};
        for (int c = 0; c < 3; c++) begin
            sc[c]  = 28'(r_p[c]) * 28'd5243;
            scq[c] = sc[c][27:19];
            scs[c] = (scq[c] > 9'd255) ? 8'd255 : scq[c][7:0];
        end
    end

    // memory port selection
    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_i[AW-1:0];
        mem_we = 1'b0;
        mem_wa = r_i[AW-1:0];
        mem_wd = '0;
        unique case (r_state)
            ST_CRD: begin
                mem_re = 1'b1;
            end
            ST_CDV: begin
                mem_we = div_done;
                mem_wd = (h_sub < flr) ? flr : h_sub;
            end
            ST_DRD1: begin
                mem_re = 1'b1;
                mem_ra = AW'(r_k - 7'd1);
            end
            ST_DRD2: begin
                mem_re = 1'b1;
                mem_ra = AW'(r_k - 7'd2);
            end
            ST_DWR: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_k);
                mem_wd = dprod[18:11];
            end
            ST_SP5: begin
                mem_re = 1'b1;
                mem_ra = AW'(r_y);
            end
            ST_SP6: begin
                mem_we = div_done;
                mem_wa = AW'(r_y);
                mem_wd = ssum[8] ? 8'd255 : ssum[7:0];
            end
            ST_ERD: begin
                mem_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_hv[mem_ra] ? r_mem[mem_ra] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= '0;
        end else if (mem_we) begin
            r_hv[mem_wa] <= 1'b1;
        end
    end

    assign o_pop = (r_state == ST_IDLE) && i_q_valid;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rng       <= 32'd1;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
            r_sim       <= 1'b0;
            r_n         <= '0;
            r_i         <= '0;
            r_k         <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (i_seed.seed_we) begin
                r_rng <= (i_seed.seed != 32'd0) ? i_seed.seed : 32'd1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_sim   <= i_q_sim;
                        r_n     <= i_n;
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    r_i <= '0;
                    if (r_sim) begin
                        if (r_n == 7'd0) begin
                            r_state <= ST_SP1;
                        end else begin
                            r_div_start <= 1'b1;
                            r_div_num   <= 32'(r_x);
                            r_div_den   <= 12'(r_n);
                            r_state     <= ST_LIM;
                        end
                    end else begin
                        r_state <= (r_n == 7'd0) ? ST_IDLE : ST_ERD;
                    end
                end
                ST_LIM: begin
                    if (div_done) begin
                        r_limit <= 11'(div_quo[10:0] + 11'd2);
                        r_state <= ST_CRD;
                    end
                end
                ST_CRD: begin
                    r_rng       <= rng_next;
                    r_div_start <= 1'b1;
                    r_div_num   <= rng_next;
                    r_div_den   <= 12'(r_limit);
                    r_state     <= ST_CDV;
                end
                ST_CDV: begin
                    if (div_done) begin
                        r_i <= r_i + 7'd1;
                        if (r_i + 7'd1 == r_n) begin
                            r_k     <= r_n - 7'd1;
                            r_state <= (r_n > 7'd2) ? ST_DRD1 : ST_SP1;
                        end else begin
                            r_state <= ST_CRD;
                        end
                    end
                end
                ST_DRD1: begin
                    r_state <= ST_DRD2;
                end
                ST_DRD2: begin
                    r_a     <= r_rdata;
                    r_state <= ST_DWR;
                end
                ST_DWR: begin
                    r_k     <= r_k - 7'd1;
                    r_state <= (r_k == 7'd2) ? ST_SP1 : ST_DRD1;
                end
                ST_SP1: begin
                    r_rng <= rng_next;
                    r_i   <= '0;
                    if (9'(rng_next[7:0]) <= r_si) begin
                        r_state <= ST_SP2;
                    end else begin
                        r_state <= (r_n == 7'd0) ? ST_IDLE : ST_ERD;
                    end
                end
                ST_SP2: begin
                    r_rng       <= rng_next;
                    r_div_start <= 1'b1;
                    r_div_num   <= rng_next;
                    r_div_den   <= 12'(r_ign);
                    r_state     <= ST_SP3;
                end
                ST_SP3: begin
                    if (div_done) begin
                        r_y         <= div_rem[2:0];
                        r_div_start <= 1'b1;
                        r_div_num   <= 32'(boost_num);
                        r_div_den   <= 12'(r_ign);
                        r_state     <= ST_SP4;
                    end
                end
                ST_SP4: begin
                    if (div_done) begin
                        r_lo       <= 9'd96 + {boost, 1'b0};
                        r_rng_span <= 7'(8'd112 - boost);
                        r_state    <= ST_SP5;
                    end
                end
                ST_SP5: begin
                    r_rng       <= rng_next;
                    r_div_start <= 1'b1;
                    r_div_num   <= rng_next;
                    r_div_den   <= 12'(r_rng_span);
                    r_state     <= ST_SP6;
                end
                ST_SP6: begin
                    if (div_done) begin
                        r_state <= (r_n == 7'd0) ? ST_IDLE : ST_ERD;
                    end
                end
                ST_ERD: begin
                    r_state <= ST_E1;
                end
                ST_E1: begin
                    r_t191  <= 16'(tcl) * 16'd191;
                    r_state <= ST_E2;
                end
                ST_E2: begin
                    if (t192[7]) begin
                        r_c[0] <= 8'd255;
                        r_c[1] <= 8'd255;
                        r_c[2] <= up;
                    end else if (t192[6]) begin
                        r_c[0] <= 8'd255;
                        r_c[1] <= up;
                        r_c[2] <= 8'd0;
                    end else begin
                        r_c[0] <= up;
                        r_c[1] <= 8'd0;
                        r_c[2] <= 8'd0;
                    end
                    r_state <= ST_E3;
                end
                ST_E3: begin
                    for (int c = 0; c < 3; c++) begin
                        r_p[c] <= 15'(r_c[c]) * 15'(i_cfg.brightness);
                    end
                    r_state <= ST_E4;
                end
                ST_E4: begin
                    r_ored   <= scs[0];
                    r_ogreen <= scs[1];
                    r_oblue  <= scs[2];
                    r_ovalid <= 1'b1;
                    r_state  <= ST_EOUT;
                end
                ST_EOUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_i      <= r_i + 7'd1;
                        r_state  <= (r_i + 7'd1 == r_n) ? ST_IDLE : ST_ERD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_index = r_i[5:0];
    assign o_red         = r_ored;
    assign o_green       = r_ogreen;
    assign o_blue        = r_oblue;
    assign o_last_pixel  = (r_i + 7'd1) == r_n;
endmodule

>>> src/led_fire_heat_simulator_top.sv
// ----------------------------------------------------------------------------
// led_fire_heat_simulator_top
// fire heat simulation over an led strip with heat ramp colour output
// ----------------------------------------------------------------------------
// Each frame tick gives one colour transaction per active pixel, in index
// order, the last one flagged. Each pixel passes the states ERD, E1 to E4 and
// EOUT and waits in EOUT while the output stalls. A tick whose time>>5 differs
// from the previous one first runs a simulation step on the shared divider:
// a limit division, a cooling division per cell, a drift pass, and the spark,
// which takes up to three divisions. The heat store is cleared at reset by
// valid bits, so no clearing pass is needed. Up to two ticks queue ahead.
module led_fire_heat_simulator_top #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfhs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lfhs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_time_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [5:0]                        o_pixel_index,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic                              o_last_pixel
);
    lfhs_pkg::t_cfg  r_cfg;
    lfhs_pkg::t_seed seed;
    logic [6:0]      n_active;
    logic            push;
    logic            sim;
    logic            full;
    logic            q_valid;
    logic            q_sim;
    logic            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed       <= 7'd50;
            r_cfg.intensity   <= 7'd50;
            r_cfg.brightness  <= 7'd100;
            r_cfg.pixel_count <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfhs_pkg::CFG_SPEED:      r_cfg.speed       <= i_cfg_data[6:0];
                lfhs_pkg::CFG_INTENSITY:  r_cfg.intensity   <= i_cfg_data[6:0];
                lfhs_pkg::CFG_BRIGHTNESS: r_cfg.brightness  <= i_cfg_data[6:0];
                lfhs_pkg::CFG_PIXELS:     r_cfg.pixel_count <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign seed.seed_we = i_cfg_we && (i_cfg_idx == lfhs_pkg::CFG_SEED);
    assign seed.seed    = i_cfg_data;
    assign n_active     = (r_cfg.pixel_count > 7'(MAX_PIXELS)) ? 7'(MAX_PIXELS)
                                                               : r_cfg.pixel_count;

    lfhs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_time_ms (i_time_ms),
        .i_full    (full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_sim     (sim)
    );

    lfhs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_sim   (sim),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_sim   (q_sim)
    );

    lfhs_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_seed        (seed),
        .i_n           (n_active),
        .i_q_valid     (q_valid),
        .i_q_sim       (q_sim),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last_pixel  (o_last_pixel)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full && !pop))
        else $error("tick queue overflow");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty tick queue");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_pixel) |=> !o_valid)
        else $error("output continues after last pixel");
endmodule

>>> tb/tb_led_fire_heat_simulator_top.sv
// ----------------------------------------------------------------------------
// tb_led_fire_heat_simulator_top
// self-checking testbench of the fire heat simulator
// ----------------------------------------------------------------------------
// Frame ticks are driven with random gaps while the colour output is stalled
// at random. A scoreboard keeps its own heat store, generator and settings,
// predicts each pixel colour of every accepted tick, and checks the output
// transactions in order. Settings change only while the block is idle.

class fire_scoreboard;
    logic [7:0]  heat [64];
    logic [26:0] last_iter;
    logic [31:0] rng;
    int unsigned speed, intensity, bright, pixels;
    logic [31:0] exp_color [$];
    logic [6:0]  exp_tag [$];
    int errors;
    int checked;

    function new();
        foreach (heat[i]) heat[i] = '0;
        last_iter = '0;
        rng = 32'd1;
        speed = 50; intensity = 50; bright = 100; pixels = 64;
        errors = 0;
        checked = 0;
    endfunction

    function logic [31:0] next_rand();
        logic [31:0] x;
        x = rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng = x;
        return x;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            lfhs_pkg::CFG_SPEED:      speed = val[6:0];
            lfhs_pkg::CFG_INTENSITY:  intensity = val[6:0];
            lfhs_pkg::CFG_BRIGHTNESS: bright = val[6:0];
            lfhs_pkg::CFG_PIXELS:     pixels = val[6:0];
            lfhs_pkg::CFG_SEED:       rng = (val != 0) ? val : 32'd1;
            default: ;
        endcase
    endfunction

    function void run_step(int unsigned n);
        int unsigned ign, sp, lim, cool, flr, h, t, y, boost, lo, hi, spk, s;
        ign = (n / 10 > 3) ? n / 10 : 3;
        sp = speed * 255 / 100;
        for (int i = 0; i < n; i++) begin
            lim = ((20 + sp / 3) * 16) / n + 2;
            cool = (next_rand() % lim) & 8'hFF;
            flr = (i < ign) ? (ign - i) / 4 + 16 : 0;
            h = heat[i];
            t = (h > cool) ? h - cool : 0;
            heat[i] = 8'((t < flr) ? flr : t);
        end
        for (int i = n; i > 2; i--)
            heat[i-1] = 8'((int'(heat[i-2]) + 2 * int'(heat[i-3])) / 3);
        if ((next_rand() % 256) <= intensity * 255 / 100) begin
            y = next_rand() % ign;
            boost = (33 * (ign - y / 2) / ign) & 8'hFF;
            lo = 96 + 2 * boost;
            hi = 207 + boost;
            spk = (lo + next_rand() % (hi - lo + 1)) & 8'hFF;
            s = heat[y & 63] + spk;
            heat[y & 63] = 8'((s > 255) ? 255 : s);
        end
    endfunction

    function int unsigned pct(int unsigned c);
        int unsigned v;
        v = c * bright / 100;
        return (v > 255) ? 255 : v;
    endfunction

    function void note_tick(logic [31:0] tms);
        int unsigned n, tt, t192, up, r, g, b;
        n = (pixels > 64) ? 64 : pixels;
        if (tms[31:5] != last_iter) begin
            run_step(n);
            last_iter = tms[31:5];
        end
        for (int i = 0; i < n; i++) begin
            tt = (heat[i] > 240) ? 240 : heat[i];
            t192 = tt * 191 / 255;
            up = (t192 & 8'h3F) << 2;
            if (t192 & 8'h80) begin
                r = 255; g = 255; b = up;
            end else if (t192 & 8'h40) begin
                r = 255; g = up; b = 0;
            end else begin
                r = up; g = 0; b = 0;
            end
            exp_color.push_back({8'd0, 8'(pct(r)), 8'(pct(g)), 8'(pct(b))});
            exp_tag.push_back({(i + 1 == n), 6'(i)});
        end
    endfunction

    function void check_pixel(logic [5:0] idx, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic lastp);
        logic [31:0] c;
        logic [6:0]  tg;
        checked++;
        if (exp_color.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction idx=%0d", $time, idx);
            return;
        end
        c = exp_color.pop_front();
        tg = exp_tag.pop_front();
        if (idx != tg[5:0]) begin
            errors++;
            $display("%0t: index exp %0d got %0d", $time, tg[5:0], idx);
        end
        if (r != c[23:16]) begin
            errors++;
            $display("%0t: red exp %0d got %0d", $time, c[23:16], r);
        end
        if (g != c[15:8]) begin
            errors++;
            $display("%0t: green exp %0d got %0d", $time, c[15:8], g);
        end
        if (b != c[7:0]) begin
            errors++;
            $display("%0t: blue exp %0d got %0d", $time, c[7:0], b);
        end
        if (lastp != tg[6]) begin
            errors++;
            $display("%0t: last exp %0d got %0d", $time, tg[6], lastp);
        end
    endfunction
endclass

module tb_led_fire_heat_simulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [lfhs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lfhs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_valid;
    logic                            o_stall;
    logic [31:0]                     i_time_ms;
    logic                            o_valid;
    logic                            i_stall;
    logic [5:0]                      o_pixel_index;
    logic [7:0]                      o_red, o_green, o_blue;
    logic                            o_last_pixel;

    fire_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off;
    longint cycle_count = 0;
    logic [31:0] now_ms;
    int  ticks_sent;

    led_fire_heat_simulator_top DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd6000000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= hold_off || ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall)
            board.check_pixel(o_pixel_index, o_red, o_green, o_blue, o_last_pixel);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_valid    <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        board.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high after a transaction so that ticks can follow back to back
    task automatic send_tick(logic [31:0] tms);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_time_ms <= tms;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_tick(tms);
        ticks_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.exp_color.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    // mostly advancing time, sometimes repeated or jumping
    task automatic random_ticks(int count);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: now_ms = now_ms;
                1: now_ms = $urandom;
                default: now_ms = now_ms + $urandom_range(1, 80);
            endcase
            send_tick(now_ms);
        end
    endtask

    initial begin
        board = new();
        ticks_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_time_ms = '0;
        now_ms = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, same iteration, time extremes
        send_tick(32'd0);
        send_tick(32'd31);
        send_tick(32'd32);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'hFFFF_FFE0);
        send_tick(32'h8000_0000);
        drain();
        write_reg(lfhs_pkg::CFG_PIXELS, 32'd3);
        write_reg(lfhs_pkg::CFG_SPEED, 32'd100);
        write_reg(lfhs_pkg::CFG_INTENSITY, 32'd127);
        write_reg(lfhs_pkg::CFG_BRIGHTNESS, 32'd127);
        write_reg(lfhs_pkg::CFG_SEED, 32'd0);
        for (int k = 0; k < 5; k++) send_tick(32'd64 * (k + 1));
        drain();
        write_reg(lfhs_pkg::CFG_PIXELS, 32'd0);
        send_tick(32'd500);
        send_tick(32'd600);
        drain();
        write_reg(lfhs_pkg::CFG_PIXELS, 32'd1);
        send_tick(32'd700);
        drain();
        write_reg(lfhs_pkg::CFG_PIXELS, 32'd2);
        send_tick(32'd800);
        drain();
        write_reg(lfhs_pkg::CFG_PIXELS, 32'd127);
        write_reg(lfhs_pkg::CFG_SPEED, 32'd0);
        write_reg(lfhs_pkg::CFG_INTENSITY, 32'd0);
        write_reg(lfhs_pkg::CFG_BRIGHTNESS, 32'd0);
        write_reg(lfhs_pkg::CFG_SEED, 32'hFFFF_FFFF);
        send_tick(32'd900);
        send_tick(32'd1000);
        drain();
        write_reg(lfhs_pkg::CFG_BRIGHTNESS, 32'd55);
        write_reg(lfhs_pkg::CFG_SPEED, 32'd127);
        send_tick(32'd1100);
        drain();

        // random phases with varied settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            write_reg(lfhs_pkg::CFG_SPEED, $urandom_range(127));
            write_reg(lfhs_pkg::CFG_INTENSITY, $urandom_range(127));
            write_reg(lfhs_pkg::CFG_BRIGHTNESS, $urandom_range(127));
            write_reg(lfhs_pkg::CFG_PIXELS,
                      (ph < 6) ? $urandom_range(3, 12) : $urandom_range(127));
            write_reg(lfhs_pkg::CFG_SEED, $urandom);
            if (ph == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (4000) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    random_ticks(8);
                join
            end
            random_ticks(22);
            drain();
        end

        $display("ran %0d frame ticks, checked %0d pixel transactions", ticks_sent,
                 board.checked);
        $display("settings swept: pixel counts 0..127, sliders and brightness 0..127");
        if (board.errors == 0 && board.exp_color.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
